@@ rtl/banked_register_file_unit_defines.svh @@
// Assertion macros used by the banked register file sequencer.
`ifndef BANKED_REGISTER_FILE_UNIT_DEFINES_SVH
`define BANKED_REGISTER_FILE_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/brf_pkg.sv @@
// Types, constants and decode functions of the banked register file.
package brf_pkg;

  localparam int DATA_W = 32;

  // Register memory: plain r0-r15, FIQ r8-r14, then r13/r14 of IRQ, SVC, ABT, UND.
  localparam int RF_AW = 5;
  // Saved status memory: FIQ, IRQ, SVC, ABT, UND.
  localparam int SS_AW = 3;

  localparam logic [RF_AW-1:0] PC_ADDR     = 5'd15;
  localparam logic [RF_AW-1:0] FIQ_BASE    = 5'd16;
  localparam logic [RF_AW-1:0] SL_BASE     = 5'd23;
  localparam logic [RF_AW-1:0] FIQ_LR_ADDR = 5'd22;
  localparam logic [RF_AW-1:0] IRQ_LR_ADDR = 5'd24;

  localparam logic [SS_AW-1:0] SS_FIQ_SLOT = 3'd0;
  localparam logic [SS_AW-1:0] SS_IRQ_SLOT = 3'd1;

  // Operation codes of a request transaction.
  localparam logic [2:0] OP_RD_REG = 3'd0;
  localparam logic [2:0] OP_WR_REG = 3'd1;
  localparam logic [2:0] OP_RD_SR  = 3'd2;
  localparam logic [2:0] OP_WR_SR  = 3'd3;
  localparam logic [2:0] OP_IRQ    = 3'd4;
  localparam logic [2:0] OP_FIQ    = 3'd5;
  localparam logic [2:0] OP_RD_SS  = 3'd6;

  // Processor mode codes held in the low five status bits.
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // Bank classes derived from the mode.
  localparam logic [2:0] CLS_PLAIN = 3'd0;
  localparam logic [2:0] CLS_FIQ   = 3'd1;
  localparam logic [2:0] CLS_IRQ   = 3'd2;
  localparam logic [2:0] CLS_SVC   = 3'd3;
  localparam logic [2:0] CLS_ABT   = 3'd4;
  localparam logic [2:0] CLS_UND   = 3'd5;
  localparam logic [2:0] CLS_BAD   = 3'd6;

  localparam logic [DATA_W-1:0] STATUS_RESET = 32'h0000_0010;
  localparam logic [DATA_W-1:0] BAD_READ     = 32'hDEAD_BEEF;
  localparam logic [DATA_W-1:0] IRQ_VECTOR   = 32'h0000_0018;
  localparam logic [DATA_W-1:0] FIQ_VECTOR   = 32'h0000_001C;
  localparam logic [DATA_W-1:0] PC_MASK      = ~32'h0000_0001;

  // Write port and read address of one memory.
  typedef struct packed {
    logic              we;
    logic [RF_AW-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [RF_AW-1:0]  raddr;
  } rf_req_t;

  typedef struct packed {
    logic              we;
    logic [SS_AW-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [SS_AW-1:0]  raddr;
  } ss_req_t;

  // One result transaction.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              pc_written;
    logic              bad_mode;
  } res_t;

  // Storage location of an architectural register.
  typedef struct packed {
    logic             ok;
    logic [RF_AW-1:0] addr;
  } cell_t;

  function automatic logic [2:0] mode_class(input logic [4:0] m);
    logic [2:0] c;
    unique case (m)
      MODE_USR, MODE_SYS: c = CLS_PLAIN;
      MODE_FIQ:           c = CLS_FIQ;
      MODE_IRQ:           c = CLS_IRQ;
      MODE_SVC:           c = CLS_SVC;
      MODE_ABT:           c = CLS_ABT;
      MODE_UND:           c = CLS_UND;
      default:            c = CLS_BAD;
    endcase
    return c;
  endfunction

  // Maps a register number in a bank class to its memory address.
  function automatic cell_t cell_map(input logic [2:0] cls, input logic [3:0] r);
    cell_t      m;
    logic [2:0] off;
    off    = cls - CLS_IRQ;
    m.ok   = 1'b1;
    m.addr = {1'b0, r};
    if (r < 4'd8 || r == 4'd15) begin
      if (r == 4'd15 && cls == CLS_BAD) begin
        m.ok = 1'b0;
      end
    end else if (cls == CLS_BAD) begin
      m.ok = 1'b0;
    end else if (cls == CLS_FIQ) begin
      m.addr = FIQ_BASE + {2'b00, r[2:0]};
    end else if (cls >= CLS_IRQ && r >= 4'd13) begin
      m.addr = SL_BASE + {2'b00, off[1:0], (r == 4'd14)};
    end
    return m;
  endfunction

endpackage

@@ rtl/brf_req_if.sv @@
// Request channel: operation, register number and write value.
interface brf_req_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [3:0]        reg_index;
  logic [DATA_W-1:0] write_value;

  modport source (output valid, output mode, output reg_index, output write_value,
                  input ready);
  modport sink (input valid, input mode, input reg_index, input write_value,
                output ready);
endinterface

@@ rtl/brf_rsp_if.sv @@
// Response channel: read data and status flags.
interface brf_rsp_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              pc_written;
  logic              bad_mode;

  modport source (output valid, output read_data, output pc_written, output bad_mode,
                  input ready);
  modport sink (input valid, input read_data, input pc_written, input bad_mode,
                output ready);
endinterface

@@ rtl/brf_mem.sv @@
// Synchronous memory with one write port, one registered read port and entry valid bits.
module brf_mem import brf_pkg::*; #(
  parameter int AW = RF_AW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [DATA_W-1:0] rdata_q;
  logic              rvalid_q;

  // Storage array and registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rvalid_q <= vld[raddr];
    end
  end

  assign rdata = rvalid_q ? rdata_q : '0;

endmodule

@@ rtl/brf_seq.sv @@
// Sequencer: decodes a transaction, reads, modifies and writes back the memories.
`include "banked_register_file_unit_defines.svh"

module brf_seq import brf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  brf_req_if.sink           req,
  output rf_req_t           rf_req,
  input  logic [DATA_W-1:0] rf_rdata,
  output ss_req_t           ss_req,
  input  logic [DATA_W-1:0] ss_rdata,
  output res_t              res,
  output logic              res_valid,
  input  logic              res_ready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_VEC  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [DATA_W-1:0] status_word;
  logic [DATA_W-1:0] status_word_next;

  logic [2:0]        op;
  logic [3:0]        idx;
  logic [DATA_W-1:0] val;
  logic [2:0]        cls;
  cell_t             loc;

  logic [2:0]        cur_cls;
  cell_t             cur_cell;
  logic              accept;
  logic              is_entry;
  logic [2:0]        ss_slot;
  res_t              res_next;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign res_valid = (state == ST_RESP);
  assign is_entry  = (op == OP_IRQ) || (op == OP_FIQ);

  // Decode of the incoming transaction against the current mode.
  assign cur_cls  = mode_class(status_word[4:0]);
  assign cur_cell = cell_map(cur_cls, req.reg_index);
  assign ss_slot  = cur_cls - CLS_FIQ;

  // Control state and the status word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      status_word <= STATUS_RESET;
    end else begin
      state       <= state_next;
      status_word <= status_word_next;
    end
  end

  // Transaction fields held while it is in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req.mode;
      idx <= req.reg_index;
      val <= req.write_value;
      cls <= cur_cls;
      loc <= cur_cell;
    end
    if (state == ST_EXEC) begin
      res <= res_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) begin
        state_next = ST_EXEC;
      end
      ST_EXEC: state_next = is_entry ? ST_VEC : ST_RESP;
      ST_VEC:  state_next = ST_RESP;
      ST_RESP: if (res_ready) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Read addresses are issued at acceptance; writes happen in the later states.
  always_comb begin
    rf_req       = '0;
    ss_req       = '0;
    rf_req.raddr = ((req.mode == OP_IRQ) || (req.mode == OP_FIQ)) ? PC_ADDR
                                                                   : cur_cell.addr;
    ss_req.raddr = ss_slot;
    if (state == ST_EXEC) begin
      if (op == OP_WR_REG && loc.ok) begin
        rf_req.we    = 1'b1;
        rf_req.waddr = loc.addr;
        rf_req.wdata = (idx == 4'd15) ? (val & PC_MASK) : val;
      end else if (is_entry) begin
        // The old r15 goes to the target link register, the status to its saved slot.
        rf_req.we    = 1'b1;
        rf_req.waddr = (op == OP_FIQ) ? FIQ_LR_ADDR : IRQ_LR_ADDR;
        rf_req.wdata = rf_rdata;
        ss_req.we    = 1'b1;
        ss_req.waddr = (op == OP_FIQ) ? SS_FIQ_SLOT : SS_IRQ_SLOT;
        ss_req.wdata = status_word;
      end
    end else if (state == ST_VEC) begin
      rf_req.we    = 1'b1;
      rf_req.waddr = PC_ADDR;
      rf_req.wdata = (op == OP_FIQ) ? FIQ_VECTOR : IRQ_VECTOR;
    end
  end

  // Status word updates and the result of the transaction.
  always_comb begin
    status_word_next = status_word;
    res_next         = '0;
    res_next.bad_mode = (cls == CLS_BAD);
    if (state == ST_EXEC) begin
      unique case (op)
        OP_RD_REG: res_next.read_data = loc.ok ? rf_rdata : BAD_READ;
        OP_WR_REG: res_next.pc_written = loc.ok && (idx == 4'd15);
        OP_RD_SR:  res_next.read_data = status_word;
        OP_WR_SR:  status_word_next = val;
        OP_IRQ: begin
          status_word_next   = {status_word[DATA_W-1:6], 1'b0, MODE_IRQ};
          res_next.pc_written = 1'b1;
        end
        OP_FIQ: begin
          status_word_next   = {status_word[DATA_W-1:6], 1'b0, MODE_FIQ};
          res_next.pc_written = 1'b1;
        end
        OP_RD_SS: begin
          if (cls == CLS_BAD) begin
            res_next.read_data = BAD_READ;
          end else if (cls != CLS_PLAIN) begin
            res_next.read_data = ss_rdata;
          end
        end
        default: res_next.read_data = '0;
      endcase
    end
  end

  // Checks on the sequencing of memory writes.
  `BRF_ASSERT_NEXT(a_entry_to_vec, state == ST_EXEC && is_entry, state == ST_VEC,
                   "entry must load the vector next")
  `BRF_ASSERT_NOW(a_vec_writes_pc, state == ST_VEC, rf_req.we && rf_req.waddr == PC_ADDR,
                  "vector state must write r15")
  `BRF_ASSERT_NOW(a_pc_even, rf_req.we && rf_req.waddr == PC_ADDR, !rf_req.wdata[0],
                  "r15 written with bit 0 set")
  `BRF_ASSERT_NOW(a_ss_write_on_entry, ss_req.we, state == ST_EXEC && is_entry,
                  "saved status written outside an entry")
  `BRF_ASSERT_NEXT(a_exec_to_resp, state == ST_EXEC && !is_entry, state == ST_RESP,
                   "result must follow execution")

endmodule

@@ rtl/banked_register_file_unit.sv @@
// Mode-banked register file: one result transaction for each request transaction.
// A result passes the execute state, the vector state for IRQ or FIQ entry, the result
// state and the output register. Transactions do not overlap: each runs the read, then
// write-back sequence through the single write port of the register memory.
// Reset: valid bits of both memories clear so every register and saved status reads
// zero, the status word becomes 0x10; no clearing pass, requests are taken at once.
module banked_register_file_unit import brf_pkg::*; (
  input  logic clk,
  input  logic rst,
  brf_req_if.sink   req,
  brf_rsp_if.source rsp
);

  rf_req_t           rf_req;
  ss_req_t           ss_req;
  logic [DATA_W-1:0] rf_rdata;
  logic [DATA_W-1:0] ss_rdata;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid;
  res_t              out_data;

  brf_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rf_req    (rf_req),
    .rf_rdata  (rf_rdata),
    .ss_req    (ss_req),
    .ss_rdata  (ss_rdata),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  brf_mem #(.AW(RF_AW)) u_rf_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (rf_req.we),
    .waddr (rf_req.waddr),
    .wdata (rf_req.wdata),
    .raddr (rf_req.raddr),
    .rdata (rf_rdata)
  );

  brf_mem #(.AW(SS_AW)) u_ss_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (ss_req.we),
    .waddr (ss_req.waddr),
    .wdata (ss_req.wdata),
    .raddr (ss_req.raddr),
    .rdata (ss_rdata)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_data.read_data;
  assign rsp.pc_written = out_data.pc_written;
  assign rsp.bad_mode   = out_data.bad_mode;

endmodule

@@ tb/sv/tb_banked_register_file_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the mode-banked register file with a mirror of its state.
module tb_banked_register_file_unit;
  import brf_pkg::*;

  localparam int unsigned RANDOM_ACCESSES = 825;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 8;

  // How much each side idles during a stretch of the run.
  typedef enum logic [1:0] {
    PH_SEND_IDLE,
    PH_RECV_IDLE,
    PH_NO_IDLE
  } idle_phase_t;

  // One request transaction, plus its stimulus controls.
  typedef struct {
    logic [2:0]  op;
    logic [3:0]  idx;
    logic [31:0] val;
    bit          drain_first;
    idle_phase_t phase;
  } access_t;

  logic clk = 1'b0;
  logic rst;

  brf_req_if req_ch ();
  brf_rsp_if rsp_ch ();

  banked_register_file_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Mirror of the architectural state.
  logic [31:0] user_regs  [0:15];
  logic [31:0] fiq_regs   [8:14];
  logic [31:0] stack_link [CLS_IRQ:CLS_UND][13:14];
  logic [31:0] saved_sr   [CLS_FIQ:CLS_UND];
  logic [31:0] status_q;

  access_t     access_queue [$];
  res_t        predicted_results [$];
  access_t     in_flight;
  res_t        want;
  idle_phase_t active_phase = PH_SEND_IDLE;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  logic [4:0] legal_modes [0:6] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
                                    MODE_ABT, MODE_UND, MODE_SYS};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Maps the low status bits to the register bank in use.
  function automatic logic [2:0] bank_of(input logic [4:0] m);
    unique case (m)
      MODE_USR, MODE_SYS: return CLS_PLAIN;
      MODE_FIQ:           return CLS_FIQ;
      MODE_IRQ:           return CLS_IRQ;
      MODE_SVC:           return CLS_SVC;
      MODE_ABT:           return CLS_ABT;
      MODE_UND:           return CLS_UND;
      default:            return CLS_BAD;
    endcase
  endfunction

  // Applies one access to the mirror and returns the result it must produce.
  function automatic res_t resolve_access(input access_t a);
    res_t        r;
    logic [2:0]  cls;
    logic [31:0] v;
    cls = bank_of(status_q[4:0]);
    v = a.val;
    r = '0;
    r.bad_mode = (cls == CLS_BAD);
    unique case (a.op)
      OP_RD_REG, OP_WR_REG: begin
        if (cls == CLS_BAD && a.idx >= 4'd8) begin
          // Banked registers and the PC are out of reach in an unknown mode.
          if (a.op == OP_RD_REG) r.read_data = BAD_READ;
        end else begin
          if (a.op == OP_WR_REG && a.idx == 4'd15) begin
            v = v & PC_MASK;
            r.pc_written = 1'b1;
          end
          if (a.idx < 4'd8 || a.idx == 4'd15 || cls == CLS_PLAIN ||
              (cls != CLS_FIQ && a.idx < 4'd13)) begin
            if (a.op == OP_WR_REG) user_regs[a.idx] = v;
            else r.read_data = user_regs[a.idx];
          end else if (cls == CLS_FIQ) begin
            if (a.op == OP_WR_REG) fiq_regs[a.idx] = v;
            else r.read_data = fiq_regs[a.idx];
          end else begin
            if (a.op == OP_WR_REG) stack_link[cls][a.idx] = v;
            else r.read_data = stack_link[cls][a.idx];
          end
        end
      end
      OP_RD_SR: r.read_data = status_q;
      OP_WR_SR: status_q = v;
      OP_IRQ: begin
        saved_sr[CLS_IRQ] = status_q;
        stack_link[CLS_IRQ][14] = user_regs[15];
        status_q = {status_q[31:6], 1'b0, MODE_IRQ};
        user_regs[15] = IRQ_VECTOR;
        r.pc_written = 1'b1;
      end
      OP_FIQ: begin
        saved_sr[CLS_FIQ] = status_q;
        fiq_regs[14] = user_regs[15];
        status_q = {status_q[31:6], 1'b0, MODE_FIQ};
        user_regs[15] = FIQ_VECTOR;
        r.pc_written = 1'b1;
      end
      OP_RD_SS: begin
        if (cls == CLS_BAD) r.read_data = BAD_READ;
        else if (cls != CLS_PLAIN) r.read_data = saved_sr[cls];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned send_idle_pct(input idle_phase_t p);
    return (p == PH_SEND_IDLE) ? 37 : (p == PH_RECV_IDLE) ? 46 : 0;
  endfunction

  function automatic int unsigned recv_idle_pct(input idle_phase_t p);
    return (p == PH_SEND_IDLE) ? 46 : (p == PH_RECV_IDLE) ? 37 : 0;
  endfunction

  task automatic queue_access(input logic [2:0] op, input logic [3:0] idx,
                              input logic [31:0] val, input bit drain,
                              input idle_phase_t phase);
    access_t a;
    a.op = op;
    a.idx = idx;
    a.val = val;
    a.drain_first = drain;
    a.phase = phase;
    access_queue.push_back(a);
  endtask

  // Request driver: predicts each accepted transaction and presents the next one.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predicted_results.push_back(resolve_access(in_flight));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (access_queue.size() != 0 &&
            !(access_queue[0].drain_first && predicted_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct(access_queue[0].phase)) begin
          in_flight = access_queue.pop_front();
          active_phase <= in_flight.phase;
          req_ch.valid <= 1'b1;
          req_ch.mode <= in_flight.op;
          req_ch.reg_index <= in_flight.idx;
          req_ch.write_value <= in_flight.val;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result: read_data %h", rsp_ch.read_data);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          if (rsp_ch.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, rsp_ch.read_data);
            mismatch_count++;
          end
          if (rsp_ch.pc_written !== want.pc_written) begin
            $error("pc_written: expected %b, got %b", want.pc_written, rsp_ch.pc_written);
            mismatch_count++;
          end
          if (rsp_ch.bad_mode !== want.bad_mode) begin
            $error("bad_mode: expected %b, got %b", want.bad_mode, rsp_ch.bad_mode);
            mismatch_count++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct(active_phase));
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    logic [2:0]  op;
    logic [3:0]  idx;
    logic [31:0] val;
    idle_phase_t phase;
    bit          drain;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = OP_RD_REG;
    req_ch.reg_index = '0;
    req_ch.write_value = '0;
    rsp_ch.ready = 1'b0;

    // The mirror starts from the reset state of the block.
    for (int r = 0; r < 16; r++) user_regs[r] = '0;
    for (int r = 8; r <= 14; r++) fiq_regs[r] = '0;
    for (int c = CLS_IRQ; c <= CLS_UND; c++) begin
      stack_link[c][13] = '0;
      stack_link[c][14] = '0;
    end
    for (int c = CLS_FIQ; c <= CLS_UND; c++) saved_sr[c] = '0;
    status_q = STATUS_RESET;

    // Directed part: field extremes, the PC rules, entries and an unknown mode.
    queue_access(OP_RD_REG, 4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_WR_REG, 4'd0,  32'hFFFF_FFFF, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_REG, 4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_WR_REG, 4'd15, 32'hFFFF_FFFF, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_REG, 4'd15, 32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_SS,  4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_WR_REG, 4'd14, 32'h1234_5678, 1'b0, PH_SEND_IDLE);
    queue_access(OP_IRQ,    4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_REG, 4'd14, 32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_SS,  4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_SR,  4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    // FIQ mode with the Thumb bit and all upper bits set, then re-entry.
    queue_access(OP_WR_SR,  4'd0,  32'hFFFF_FFF1, 1'b0, PH_SEND_IDLE);
    queue_access(OP_FIQ,    4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_REG, 4'd14, 32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_WR_REG, 4'd8,  32'hA5A5_A5A5, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_SR,  4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    // Unknown mode code: upper registers and the PC are locked out.
    queue_access(OP_WR_SR,  4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_REG, 4'd8,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_WR_REG, 4'd15, 32'h5555_5555, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_SS,  4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_REG, 4'd7,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_IRQ,    4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    // System mode shares the user registers and has no saved status.
    queue_access(OP_WR_SR,  4'd0,  {27'd0, MODE_SYS}, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_SS,  4'd0,  32'h0000_0000, 1'b0, PH_SEND_IDLE);
    queue_access(OP_RD_REG, 4'd14, 32'h0000_0000, 1'b0, PH_SEND_IDLE);

    // Random part: mostly legal mode switches, with entries and banked accesses.
    for (n = 0; n < RANDOM_ACCESSES; n++) begin
      if (n < RANDOM_ACCESSES / 3) phase = PH_SEND_IDLE;
      else if (n < 2 * RANDOM_ACCESSES / 3) phase = PH_RECV_IDLE;
      else phase = PH_NO_IDLE;
      drain = (n == RANDOM_ACCESSES / 3) || (n == 2 * RANDOM_ACCESSES / 3) ||
              ($urandom_range(49) == 0);
      pick = $urandom_range(99);
      if (pick < 30) op = OP_RD_REG;
      else if (pick < 55) op = OP_WR_REG;
      else if (pick < 63) op = OP_RD_SR;
      else if (pick < 75) op = OP_WR_SR;
      else if (pick < 83) op = OP_IRQ;
      else if (pick < 90) op = OP_FIQ;
      else op = OP_RD_SS;
      idx = $urandom_range(1) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(15));
      val = $urandom;
      if (op == OP_WR_SR) begin
        if ($urandom_range(9) == 0) val[4:0] = 5'($urandom_range(31));
        else val[4:0] = legal_modes[$urandom_range(6)];
      end
      queue_access(op, idx, val, drain, phase);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (access_queue.size() != 0 || req_ch.valid || predicted_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
